// ----- src/fcp_pkg.sv -----
// ----------------------------------------------------------------------------
// fcp_pkg
// shared constants, item layout and controller/datapath interface types for
// the filtered read coverage pileup unit
// ----------------------------------------------------------------------------
`default_nettype none

package fcp_pkg;

  // coverage store geometry
  localparam int unsigned BINS       = 4096;
  localparam int unsigned COUNT_BITS = 32;
  localparam int unsigned BIN_BITS   = $clog2(BINS);
  // counter that can also hold BINS itself
  localparam int unsigned CNT_BITS   = BIN_BITS + 1;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  // unmapped, secondary, qc-fail, duplicate
  localparam logic [15:0] FLAG_DROP_MASK = 16'h0704;

  // stream widths
  localparam int unsigned IN_FIELD_BITS = 83;
  localparam int unsigned IN_DATA_BITS  = 88;
  localparam int unsigned OUT_DATA_BITS = 40;

  // configuration port
  localparam int unsigned CFG_IDX_BITS  = 2;
  localparam int unsigned CFG_DATA_BITS = 31;

  localparam logic [CFG_IDX_BITS-1:0] REG_WINDOW_START = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_WINDOW_END   = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_MIN_MAPQ     = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_MIN_LENGTH   = 2'd3;

  // item kinds (tuser)
  localparam logic KIND_READ    = 1'b0;
  localparam logic KIND_READOUT = 1'b1;

  // input tdata layout, last field in the lowest bits
  typedef struct packed {
    logic [11:0] bin_index;
    logic [7:0]  mapq;
    logic [15:0] flags;
    logic [15:0] read_length;
    logic [30:0] read_start;
  } fcp_item_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic calc_a;
    logic calc_b;
    logic calc_c;
    logic calc_d;
    logic walk_init;
    logic walk_step;
    logic clr_step;
    logic rd_bin;
    logic rd_capture;
    logic out_load;
  } fcp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_readout;
    logic pass;
    logic empty;
    logic walk_last;
    logic clr_last;
    logic out_free;
  } fcp_status_t;

endpackage

`default_nettype wire

// ----- src/fcp_ctrl.sv -----
// ----------------------------------------------------------------------------
// fcp_ctrl
// sequencer: clearing pass, item capture, span setup, bin walk, readout,
// result hand-off
// ----------------------------------------------------------------------------
`default_nettype none

module fcp_ctrl (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_tvalid,
  output logic                in_tready,
  input  wire fcp_pkg::fcp_status_t st,
  output fcp_pkg::fcp_cmd_t   cmd
);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_RD,
    S_RDW,
    S_CA,
    S_CB,
    S_CC,
    S_CD,
    S_DECIDE,
    S_WALK,
    S_DRAIN,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (st.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_CA;
        end
      end
      S_CA: begin
        // kind is known once captured
        if (st.is_readout) begin
          state_nxt = S_RD;
        end else begin
          cmd.calc_a = 1'b1;
          state_nxt  = S_CB;
        end
      end
      S_CB: begin
        cmd.calc_b = 1'b1;
        state_nxt  = S_CC;
      end
      S_CC: begin
        cmd.calc_c = 1'b1;
        state_nxt  = S_CD;
      end
      S_CD: begin
        cmd.calc_d = 1'b1;
        state_nxt  = S_DECIDE;
      end
      S_DECIDE: begin
        if (st.pass && !st.empty) begin
          cmd.walk_init = 1'b1;
          state_nxt     = S_WALK;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_WALK: begin
        cmd.walk_step = 1'b1;
        if (st.walk_last) state_nxt = S_DRAIN;
      end
      S_DRAIN: begin
        state_nxt = S_DONE;
      end
      S_RD: begin
        cmd.rd_bin = 1'b1;
        state_nxt  = S_RDW;
      end
      S_RDW: begin
        cmd.rd_capture = 1'b1;
        state_nxt      = S_DONE;
      end
      S_DONE: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- src/fcp_datapath.sv -----
// ----------------------------------------------------------------------------
// fcp_datapath
// configuration registers, read filter, span arithmetic, coverage store with
// read-modify-write pipe, output register
// ----------------------------------------------------------------------------
`default_nettype none

module fcp_datapath (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire                                  cfg_we,
  input  wire  [fcp_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  wire  [fcp_pkg::CFG_DATA_BITS-1:0]    cfg_data,
  input  wire                                  in_kind,
  input  wire  fcp_pkg::fcp_item_t             in_item,
  output logic                                 out_tvalid,
  input  wire                                  out_tready,
  output logic                                 out_accepted,
  output logic [31:0]                          out_bin_count,
  input  wire  fcp_pkg::fcp_cmd_t              cmd,
  output fcp_pkg::fcp_status_t                 st
);

  localparam logic [31:0] BINS_W32 = 32'(fcp_pkg::BINS);

  // configuration
  logic [30:0] ws_r, we_r;
  logic [7:0]  min_mapq_r;
  logic [15:0] min_len_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ws_r       <= '0;
      we_r       <= '0;
      min_mapq_r <= '0;
      min_len_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        fcp_pkg::REG_WINDOW_START: ws_r       <= cfg_data[30:0];
        fcp_pkg::REG_WINDOW_END:   we_r       <= cfg_data[30:0];
        fcp_pkg::REG_MIN_MAPQ:     min_mapq_r <= cfg_data[7:0];
        fcp_pkg::REG_MIN_LENGTH:   min_len_r  <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // captured item
  logic               kind_r;
  fcp_pkg::fcp_item_t item_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_r <= in_kind;
      item_r <= in_item;
    end
  end

  // span arithmetic, one wide step per stage
  logic [31:0]                   rend_r, hi_abs_r, hi_rel_r;
  logic [30:0]                   lo_abs_r, lo_rel_r;
  logic                          pass_r, ordered_bad_r, empty_r;
  logic [fcp_pkg::CNT_BITS-1:0]  lo_r, hi_r;

  always_ff @(posedge clk) begin
    if (cmd.calc_a) begin
      rend_r   <= {1'b0, item_r.read_start} + {16'd0, item_r.read_length};
      lo_abs_r <= (item_r.read_start > ws_r) ? item_r.read_start : ws_r;
      pass_r   <= ((item_r.flags & fcp_pkg::FLAG_DROP_MASK) == 16'd0)
               && (item_r.mapq >= min_mapq_r)
               && ((min_len_r == 16'd0) || (item_r.read_length >= min_len_r));
    end
    if (cmd.calc_b) begin
      hi_abs_r <= (rend_r < {1'b0, we_r}) ? rend_r : {1'b0, we_r};
    end
    if (cmd.calc_c) begin
      ordered_bad_r <= (hi_abs_r <= {1'b0, lo_abs_r});
      lo_rel_r      <= lo_abs_r - ws_r;
      hi_rel_r      <= hi_abs_r - {1'b0, ws_r};
    end
    if (cmd.calc_d) begin
      // a span that starts past the last bin is empty after clipping
      empty_r <= ordered_bad_r || ({1'b0, lo_rel_r} >= BINS_W32);
      lo_r    <= fcp_pkg::CNT_BITS'(lo_rel_r);
      hi_r    <= (hi_rel_r > BINS_W32) ? fcp_pkg::CNT_BITS'(fcp_pkg::BINS)
                                       : fcp_pkg::CNT_BITS'(hi_rel_r);
    end
  end

  // shared bin counter: clearing pass and span walk
  logic [fcp_pkg::CNT_BITS-1:0] cnt_r, cnt_nxt, cnt_inc;

  assign cnt_inc = cnt_r + fcp_pkg::CNT_BITS'(1);

  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.walk_init) begin
      cnt_nxt = lo_r;
    end else if (cmd.clr_step || cmd.walk_step) begin
      cnt_nxt = cnt_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // coverage store
  logic [fcp_pkg::COUNT_BITS-1:0] mem [fcp_pkg::BINS];
  logic [fcp_pkg::COUNT_BITS-1:0] rdata_r, rdata_sat, mem_wdata;
  logic [fcp_pkg::BIN_BITS-1:0]   rd_addr, mem_waddr, rmw_addr_r, bin_addr;
  logic                           mem_we, rmw_v_r, bin_in_range;

  assign bin_addr     = fcp_pkg::BIN_BITS'(32'(item_r.bin_index));
  assign bin_in_range = (32'(item_r.bin_index) < BINS_W32);
  assign rd_addr      = cmd.rd_bin ? bin_addr : cnt_r[fcp_pkg::BIN_BITS-1:0];
  assign rdata_sat    = (rdata_r == fcp_pkg::COUNT_MAX) ? rdata_r
                        : rdata_r + fcp_pkg::COUNT_BITS'(1);

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cnt_r[fcp_pkg::BIN_BITS-1:0];
    mem_wdata = '0;
    if (cmd.clr_step) begin
      mem_we = 1'b1;
    end else if (rmw_v_r) begin
      mem_we    = 1'b1;
      mem_waddr = rmw_addr_r;
      mem_wdata = rdata_sat;
    end else if (cmd.rd_capture && bin_in_range) begin
      mem_we    = 1'b1;
      mem_waddr = bin_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rdata_r <= mem[rd_addr];
  end

  // write-back half of the read-modify-write pipe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rmw_v_r <= 1'b0;
    end else begin
      rmw_v_r <= cmd.walk_step;
    end
    rmw_addr_r <= cnt_r[fcp_pkg::BIN_BITS-1:0];
  end

  // readout value and output register
  logic [31:0] res_count_r, out_count_r;
  logic        out_valid_r, out_acc_r;

  always_ff @(posedge clk) begin
    if (cmd.rd_capture) begin
      res_count_r <= bin_in_range ? 32'(rdata_r) : 32'd0;
    end
    if (cmd.out_load) begin
      out_acc_r   <= (kind_r == fcp_pkg::KIND_READ) && pass_r;
      out_count_r <= (kind_r == fcp_pkg::KIND_READOUT) ? res_count_r : 32'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_tvalid    = out_valid_r;
  assign out_accepted  = out_acc_r;
  assign out_bin_count = out_count_r;

  assign st.is_readout = (kind_r == fcp_pkg::KIND_READOUT);
  assign st.pass       = pass_r;
  assign st.empty      = empty_r;
  assign st.walk_last  = (cnt_inc == hi_r);
  assign st.clr_last   = (cnt_r == fcp_pkg::CNT_BITS'(fcp_pkg::BINS - 1));
  assign st.out_free   = !out_valid_r || out_tready;

  // write-back never lands on the bin being read in the same cycle
  a_rmw_no_collide: assert property (@(posedge clk) disable iff (!rst_n)
    (rmw_v_r && cmd.walk_step) |-> (rmw_addr_r != rd_addr))
    else $error("rmw write collides with read");

  // a pending result is never overwritten
  a_out_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_tready))
    else $error("output register overwritten");

  // walk stays inside the span and the store
  a_walk_in_span: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.walk_step |-> ((cnt_r < hi_r) && (hi_r <= fcp_pkg::CNT_BITS'(fcp_pkg::BINS))))
    else $error("bin walk out of span");

  // a walk only starts on a passing read with a non-empty span
  a_walk_start: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.walk_init |-> (pass_r && !empty_r && (lo_r < hi_r)))
    else $error("walk started on empty span");

endmodule

`default_nettype wire

// ----- src/filtered_read_coverage_pileup_unit.sv -----
// ----------------------------------------------------------------------------
// filtered_read_coverage_pileup_unit
// coverage pileup over a reference window from a stream of filtered reads
// ----------------------------------------------------------------------------
// Each read item (tuser low) is filtered on its flag word, mapping quality and
// length; a passing read adds one to every bin it overlaps inside the window,
// with counts saturating. A readout item (tuser high) returns one bin and
// clears it. One result item comes back per input item. After reset all 4096
// bins of the store are swept to zero, one bin per cycle, during which no item
// is taken (configuration writes are). Items are handled one at a time: a read
// is captured, its filter and span are worked out step by step and decided on;
// a read that piles up then walks its overlapped bins one per cycle through
// the read-modify-write pipe of the coverage memory, so it takes longer the
// more bins it overlaps. A readout is captured, and its bin is read and cleared.
// Either kind then waits until the output register is free to take its result.
// A result waits in an output register, and the next item is taken while it
// is still pending.
`default_nettype none

module filtered_read_coverage_pileup_unit (
  input  wire                                  clk,
  input  wire                                  rst_n,
  // configuration
  input  wire                                  cfg_we,
  input  wire  [fcp_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  wire  [fcp_pkg::CFG_DATA_BITS-1:0]    cfg_data,
  // input items
  input  wire                                  in_tvalid,
  output logic                                 in_tready,
  // read_start[30:0], read_length[46:31], flags[62:47], mapq[70:63],
  // bin_index[82:71], zero pad[87:83]
  input  wire  [fcp_pkg::IN_DATA_BITS-1:0]     in_tdata,
  // kind[0]: 0 read record, 1 readout and clear
  input  wire                                  in_tuser,
  // result items
  output logic                                 out_tvalid,
  input  wire                                  out_tready,
  // accepted[0], bin_count[32:1], zero pad[39:33]
  output logic [fcp_pkg::OUT_DATA_BITS-1:0]    out_tdata
);

  fcp_pkg::fcp_cmd_t    cmd;
  fcp_pkg::fcp_status_t st;
  fcp_pkg::fcp_item_t   in_item;
  logic                 out_accepted;
  logic [31:0]          out_bin_count;

  // unpack the stream word into item fields
  assign in_item = fcp_pkg::fcp_item_t'(in_tdata[fcp_pkg::IN_FIELD_BITS-1:0]);

  assign out_tdata = {7'd0, out_bin_count, out_accepted};

  fcp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .st        (st),
    .cmd       (cmd)
  );

  fcp_datapath u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_kind       (in_tuser),
    .in_item       (in_item),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_accepted  (out_accepted),
    .out_bin_count (out_bin_count),
    .cmd           (cmd),
    .st            (st)
  );

endmodule

`default_nettype wire
